FILE: rtl/msts_pkg.sv
// ----------------------------------------------------------------------------
// msts_pkg: shared definitions of the multiway sorted table search
// Constants, the token control word that moves along the cell chain, and
// the signed key compare used by the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package msts_pkg;

    // Key width of table entries and search keys.
    localparam int KEY_W = 32;

    // Default sizes handed to the top level.
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_WAYS        = 33;
    localparam int DEFAULT_CELL_BITS   = 2;

    // Configuration port geometry and register indexes.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_IW = APB_AW - 2;
    localparam logic [REG_IW-1:0] REG_ENTRIES_IN_USE = '0;

    // Item operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Control word of a token travelling through the cell chain.
    typedef struct packed {
        logic valid;
        logic write;
        logic epoch;
        logic last;
    } tok_ctrl_t;

    // Signed compare a <= b on two's complement keys.
    function automatic logic key_le(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
        return a <= b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/msts_cell.sv
// ----------------------------------------------------------------------------
// msts_cell: one cell of the table chain
// Holds one contiguous bank of the key table. Each token is registered
// in the cell as it passes: a load token writes the bank when its address
// falls here, a probe token picks up the stored key on its way.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_cell #(
    parameter int ADDR_W  = 10,
    parameter int BANK_AW = 8,
    parameter int CELL_ID = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  msts_pkg::tok_ctrl_t        in_ctrl,
    input  logic [ADDR_W-1:0]          in_addr,
    input  logic [msts_pkg::KEY_W-1:0] in_key,
    input  logic [msts_pkg::KEY_W-1:0] in_data,
    output msts_pkg::tok_ctrl_t        out_ctrl,
    output logic [ADDR_W-1:0]          out_addr,
    output logic [msts_pkg::KEY_W-1:0] out_key,
    output logic [msts_pkg::KEY_W-1:0] out_data
);
    import msts_pkg::*;

    localparam int  BANK_DEPTH = 2 ** BANK_AW;
    // A cell whose bank lies wholly above the address space holds nothing.
    localparam bit  PRESENT    = (CELL_ID < 2 ** (ADDR_W - BANK_AW));

    logic [KEY_W-1:0]   bank_mem [BANK_DEPTH];
    logic [BANK_AW-1:0] local_addr;
    logic               hit;
    logic               wr_en;
    logic               rd_en;

    tok_ctrl_t          ctrl_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   data_reg;
    logic [KEY_W-1:0]   rd_reg;
    logic               rd_hit_reg;

    // Address decode: the upper address bits select the bank.
    assign local_addr = in_addr[BANK_AW-1:0];
    assign hit   = PRESENT && in_ctrl.valid &&
                   ((in_addr >> BANK_AW) == ADDR_W'(CELL_ID));
    assign wr_en = hit && in_ctrl.write;
    assign rd_en = hit && !in_ctrl.write;

    // Bank write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank_mem[local_addr] <= in_key;
        end
        if (rd_en)
        begin
            rd_reg <= bank_mem[local_addr];
        end
    end

    // Token control stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg   <= in_ctrl;
            rd_hit_reg <= rd_en;
        end
    end

    // Token payload stage.
    always_ff @(posedge clk)
    begin
        addr_reg <= in_addr;
        key_reg  <= in_key;
        data_reg <= in_data;
    end

    // Hand the token on, with the stored key if this bank was read.
    assign out_ctrl = ctrl_reg;
    assign out_addr = addr_reg;
    assign out_key  = key_reg;
    assign out_data = rd_hit_reg ? rd_reg : data_reg;

endmodule

`default_nettype wire

FILE: rtl/msts_ctrl.sv
// ----------------------------------------------------------------------------
// msts_ctrl: search sequencer
// Takes items, injects load and probe tokens at the head of the cell chain,
// evaluates probe results at its tail level by level and emits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_ctrl #(
    parameter  int TABLE_DEPTH = msts_pkg::DEFAULT_TABLE_DEPTH,
    parameter  int WAYS        = msts_pkg::DEFAULT_WAYS,
    localparam int AW          = $clog2(TABLE_DEPTH),
    localparam int PW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       op,
    input  logic [AW-1:0]              entry_index,
    input  logic [msts_pkg::KEY_W-1:0] key,
    input  logic [PW-1:0]              count_cfg,
    output logic                       busy,
    output msts_pkg::tok_ctrl_t        head_ctrl,
    output logic [AW-1:0]              head_addr,
    output logic [msts_pkg::KEY_W-1:0] head_key,
    input  msts_pkg::tok_ctrl_t        tail_ctrl,
    input  logic [AW-1:0]              tail_addr,
    input  logic [msts_pkg::KEY_W-1:0] tail_key,
    input  logic [msts_pkg::KEY_W-1:0] tail_data,
    output logic                       done,
    output logic [PW-1:0]              position,
    output logic                       empty_table
);
    import msts_pkg::*;

    // Stride = (n - 1) / (WAYS - 1) by multiplication with a reciprocal.
    localparam int DIVISOR = WAYS - 1;
    localparam int RL      = $clog2(DIVISOR);
    localparam int SH      = PW + RL;
    localparam int PRW     = SH + PW;
    localparam int RECIP   = ((1 << SH) + DIVISOR - 1) / DIVISOR;
    localparam logic [PRW-1:0] RECIP_V = PRW'(RECIP);
    localparam logic [PW-1:0]  DEPTH_V = PW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     n_reg, n_next;
    logic [PW-1:0]     end_reg, end_next;
    logic [PW-1:0]     last_reg, last_next;
    logic              any_reg, any_next;
    logic              issuing_reg, issuing_next;
    logic              epoch_reg, epoch_next;
    logic [PW:0]       i_reg, i_next;
    logic [PRW-1:0]    prod_reg, prod_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              done_reg, done_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              empty_reg, empty_next;

    logic [PW-1:0]     cnt_sat;
    logic [PW-1:0]     stride;
    logic              linear;
    logic [PW:0]       step;
    logic [PW:0]       i_step;
    logic              issue_last;
    logic              res_hit;
    logic              res_pass;
    logic [PW-1:0]     tail_pos;
    logic [PW-1:0]     nxt_lo;
    logic [PW-1:0]     nxt_n;

    // Searched count, saturated at the table depth.
    assign cnt_sat = (count_cfg > DEPTH_V) ? DEPTH_V : count_cfg;

    // Stride of the current level; zero means a linear scan.
    assign stride     = prod_reg[SH +: PW];
    assign linear     = (stride == '0);
    assign step       = linear ? (PW+1)'(1) : {1'b0, stride};
    assign i_step     = i_reg + step;
    assign issue_last = (i_step >= {1'b0, end_reg});

    // A probe result of the current level leaves the chain.
    assign res_hit  = (state_reg == ST_RUN) && tail_ctrl.valid && !tail_ctrl.write &&
                      (tail_ctrl.epoch == epoch_reg);
    assign res_pass = key_le(tail_data, tail_key);
    assign tail_pos = PW'(tail_addr);

    // Span of the next level: after a failure it is the gap behind the last
    // passing probe, after all probes passed it is the tail of the span.
    always_comb
    begin
        nxt_lo = last_reg + PW'(1);
        nxt_n  = stride - PW'(1);
        if (res_pass)
        begin
            nxt_lo = tail_pos + PW'(1);
            nxt_n  = end_reg - PW'(1) - tail_pos;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        n_next       = n_reg;
        end_next     = end_reg;
        last_next    = last_reg;
        any_next     = any_reg;
        issuing_next = issuing_reg;
        epoch_next   = epoch_reg;
        i_next       = i_reg;
        prod_next    = prod_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        pos_next     = pos_reg;
        empty_next   = empty_reg;
        head_ctrl    = '0;
        head_addr    = entry_index;
        head_key     = key;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_LOAD)
                    begin
                        // Loads beyond the table are dropped.
                        if (PW'(entry_index) < DEPTH_V)
                        begin
                            head_ctrl.valid = 1'b1;
                            head_ctrl.write = 1'b1;
                        end
                    end
                    else
                    begin
                        key_next = key;
                        if (cnt_sat == '0)
                        begin
                            done_next  = 1'b1;
                            pos_next   = '0;
                            empty_next = 1'b1;
                        end
                        else
                        begin
                            lo_next    = '0;
                            n_next     = cnt_sat;
                            state_next = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                // Open a new level with a fresh epoch.
                prod_next    = PRW'(n_reg - PW'(1)) * RECIP_V;
                i_next       = {1'b0, lo_reg};
                end_next     = lo_reg + n_reg;
                epoch_next   = !epoch_reg;
                issuing_next = 1'b1;
                any_next     = 1'b0;
                state_next   = ST_RUN;
            end

            ST_RUN:
            begin
                // Issue one probe a cycle until the span is covered or a result ends the level.
                if (issuing_reg)
                begin
                    head_ctrl.valid = 1'b1;
                    head_ctrl.epoch = epoch_reg;
                    head_ctrl.last  = issue_last;
                    head_addr       = i_reg[AW-1:0];
                    head_key        = key_reg;
                    i_next          = i_step;
                    if (issue_last)
                    begin
                        issuing_next = 1'b0;
                    end
                end

                if (res_hit)
                begin
                    if (res_pass && !tail_ctrl.last)
                    begin
                        last_next = tail_pos;
                        any_next  = 1'b1;
                    end
                    else
                    begin
                        issuing_next = 1'b0;
                        if (linear)
                        begin
                            done_next  = 1'b1;
                            empty_next = 1'b0;
                            pos_next   = res_pass ? end_reg : tail_pos;
                            state_next = ST_IDLE;
                        end
                        else if (!res_pass && !any_reg)
                        begin
                            done_next  = 1'b1;
                            empty_next = 1'b0;
                            pos_next   = lo_reg;
                            state_next = ST_IDLE;
                        end
                        else if (nxt_n == '0)
                        begin
                            done_next  = 1'b1;
                            empty_next = 1'b0;
                            pos_next   = nxt_lo;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            lo_next    = nxt_lo;
                            n_next     = nxt_n;
                            state_next = ST_DIV;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            issuing_reg <= 1'b0;
            epoch_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            epoch_reg   <= epoch_next;
            done_reg    <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        n_reg     <= n_next;
        end_reg   <= end_next;
        last_reg  <= last_next;
        any_reg   <= any_next;
        i_reg     <= i_next;
        prod_reg  <= prod_next;
        key_reg   <= key_next;
        pos_reg   <= pos_next;
        empty_reg <= empty_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign position    = pos_reg;
    assign empty_table = empty_reg;

endmodule

`default_nettype wire

FILE: rtl/multiway_sorted_table_search.sv
// ----------------------------------------------------------------------------
// multiway_sorted_table_search: k-ary upper-bound search over a key table
// Holds an ascending table of signed keys in a chain of banked cells and
// returns, per query, the count of leading entries less than or equal to it.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. op selects a load,
//   which writes key to entry_index, or a query, which searches for key.
//   A load gives no result; busy stays low.
//   A query gives one result item: done is high for one cycle with position
//   and empty_table. The receiver cannot stall; the result is only valid in
//   that cycle. busy is low again when done rises, so a new item can follow.
//   The key table lives in 2**CELL_BITS cells; every token walks the whole
//   chain, one cell a cycle, so a probe result is back at the tail once it
//   has passed the register of every cell.
//   A query with entries_in_use zero answers in the next cycle with empty_table.
//   Otherwise each search level computes its stride, then issues probes and
//   ends on the result of probe k, the one that ends it (first failure, or
//   the last probe when all pass); k is below 2 * (WAYS - 1), or WAYS - 1 in
//   a linear scan. done follows the last level; with the default sizes a
//   query takes one or two levels.
//   entries_in_use is written over the APB port at byte address 0; the user
//   must write it only while the block is idle, which the block does not
//   enforce. Reset clears it and the sequencer; the table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module multiway_sorted_table_search #(
    parameter  int TABLE_DEPTH = msts_pkg::DEFAULT_TABLE_DEPTH,
    parameter  int WAYS        = msts_pkg::DEFAULT_WAYS,
    parameter  int CELL_BITS   = msts_pkg::DEFAULT_CELL_BITS,
    localparam int AW          = $clog2(TABLE_DEPTH),
    localparam int PW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [AW-1:0]               entry_index,
    input  logic [msts_pkg::KEY_W-1:0]  key,
    output logic                        done,
    output logic [PW-1:0]               position,
    output logic                        empty_table,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msts_pkg::APB_AW-1:0] paddr,
    input  logic [msts_pkg::APB_DW-1:0] pwdata,
    output logic [msts_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import msts_pkg::*;

    localparam int CELLS   = 2 ** CELL_BITS;
    localparam int BANK_AW = (AW > CELL_BITS) ? (AW - CELL_BITS) : 1;

    logic [PW-1:0]      count_reg, count_next;
    logic               reg_sel;

    tok_ctrl_t          chain_ctrl [CELLS+1];
    logic [AW-1:0]      chain_addr [CELLS+1];
    logic [KEY_W-1:0]   chain_key  [CELLS+1];
    logic [KEY_W-1:0]   chain_data [CELLS+1];

    // Configuration register access.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_AW-1:2] == REG_ENTRIES_IN_USE);

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            count_next = pwdata[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata = reg_sel ? APB_DW'(count_reg) : '0;

    // Search sequencer at the head and tail of the chain.
    msts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WAYS        (WAYS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .entry_index (entry_index),
        .key         (key),
        .count_cfg   (count_reg),
        .busy        (busy),
        .head_ctrl   (chain_ctrl[0]),
        .head_addr   (chain_addr[0]),
        .head_key    (chain_key[0]),
        .tail_ctrl   (chain_ctrl[CELLS]),
        .tail_addr   (chain_addr[CELLS]),
        .tail_key    (chain_key[CELLS]),
        .tail_data   (chain_data[CELLS]),
        .done        (done),
        .position    (position),
        .empty_table (empty_table)
    );

    // Probe tokens enter the chain with no data yet.
    assign chain_data[0] = '0;

    // Row of table cells, each owning one bank.
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        msts_cell #(
            .ADDR_W  (AW),
            .BANK_AW (BANK_AW),
            .CELL_ID (c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctrl  (chain_ctrl[c]),
            .in_addr  (chain_addr[c]),
            .in_key   (chain_key[c]),
            .in_data  (chain_data[c]),
            .out_ctrl (chain_ctrl[c+1]),
            .out_addr (chain_addr[c+1]),
            .out_key  (chain_key[c+1]),
            .out_data (chain_data[c+1])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/msts_checker.sv
// ----------------------------------------------------------------------------
// msts_checker: port-level checks of the multiway sorted table search
// Watches the item and result ports over time and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_checker #(
    parameter  int TABLE_DEPTH = msts_pkg::DEFAULT_TABLE_DEPTH,
    localparam int PW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  logic          op,
    input  logic          done,
    input  logic [PW-1:0] position,
    input  logic          empty_table
);
    import msts_pkg::*;

    // A result is only given once the search has stopped.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result given while search still busy");

    // An empty table always reports position zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && empty_table |-> position == '0)
        else $error("empty table result with nonzero position");

    // A result follows either a running search or a query just taken.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start && op == OP_QUERY))
        else $error("result without a query");

    // A query taken either starts a search or answers at once.
    a_query_moves: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_QUERY |=> busy || done)
        else $error("query item dropped");

    // A load never holds off the next item.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == OP_LOAD |=> !busy)
        else $error("load item made the block busy");

endmodule

bind multiway_sorted_table_search msts_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_msts_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the multiway sorted table search
// Loads key tables over the item port, sets the searched entry count over
// APB while the block is idle, and checks every query answer against a
// predictor that follows the same stride probing as the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH         = msts_pkg::DEFAULT_TABLE_DEPTH;
    localparam int WAYS          = msts_pkg::DEFAULT_WAYS;
    localparam int AW            = $clog2(DEPTH);
    localparam int POS_W         = $clog2(DEPTH + 1);
    localparam int KEY_W         = msts_pkg::KEY_W;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [msts_pkg::REG_IW-1:0] REG_SPARE = 1'b1;
    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

    // Expected answer of one query.
    typedef struct {
        logic [POS_W-1:0] position;
        logic             empty_table;
    } answer_t;

    // Keeps a copy of the key table and the entry count, predicts the
    // answer of each accepted query and compares the answers that arrive.
    class search_scoreboard;
        logic signed [KEY_W-1:0] key_store [DEPTH];
        logic [10:0]             entries_in_use;
        answer_t                 expected_answers [$];
        int                      errors;

        function new();
            entries_in_use = '0;
            errors = 0;
        endfunction

        function void set_entries(logic [31:0] data);
            entries_in_use = data[10:0];
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // Stride probing: test the stride boundaries in order, narrow to the
        // gap after the last passing probe, scan short spans one by one.
        function logic [POS_W-1:0] upper_bound_count(logic signed [KEY_W-1:0] probe_key);
            int unsigned span, lo, stride, stop, idx, passed, last;
            bit failed;
            span = (entries_in_use > DEPTH) ? DEPTH : entries_in_use;
            lo = 0;
            while (span > 0)
            begin
                stride = (span - 1) / (WAYS - 1);
                if (stride == 0)
                begin
                    while (span > 0 && key_store[lo] <= probe_key)
                    begin
                        lo++;
                        span--;
                    end
                    return lo[POS_W-1:0];
                end
                stop = lo + span;
                idx = lo;
                passed = 0;
                failed = 1'b0;
                while (idx < stop && !failed)
                begin
                    if (key_store[idx] <= probe_key)
                    begin
                        passed++;
                        idx += stride;
                    end
                    else
                        failed = 1'b1;
                end
                if (passed == 0)
                    return lo[POS_W-1:0];
                last = lo + (passed - 1) * stride;
                // After all probes pass, the tail after the last probe remains.
                span = failed ? stride - 1 : stop - 1 - last;
                lo = last + 1;
            end
            return lo[POS_W-1:0];
        endfunction

        // Notes one accepted item: loads update the table, queries queue an answer.
        function void note_item(logic item_op, logic [AW-1:0] idx, logic [KEY_W-1:0] item_key);
            answer_t ans;
            if (item_op == msts_pkg::OP_LOAD)
                key_store[idx] = item_key;
            else
            begin
                if (entries_in_use == 0)
                begin
                    ans.position = '0;
                    ans.empty_table = 1'b1;
                end
                else
                begin
                    ans.position = upper_bound_count(item_key);
                    ans.empty_table = 1'b0;
                end
                expected_answers.push_back(ans);
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        // Compares one answer with the oldest expectation.
        task check_result(logic [POS_W-1:0] got_position, logic got_empty);
            answer_t ans;
            if (expected_answers.size() == 0)
            begin
                report_mismatch($sformatf("answer with none expected: position %0d empty %0b",
                                          got_position, got_empty));
                return;
            end
            ans = expected_answers.pop_front();
            if (got_position !== ans.position)
                report_mismatch($sformatf("position %0d, expected %0d",
                                          got_position, ans.position));
            if (got_empty !== ans.empty_table)
                report_mismatch($sformatf("empty_table %0b, expected %0b",
                                          got_empty, ans.empty_table));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start;
    logic                        busy;
    logic                        op;
    logic [AW-1:0]               entry_index;
    logic [KEY_W-1:0]            key;
    logic                        done;
    logic [POS_W-1:0]            position;
    logic                        empty_table;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [msts_pkg::APB_AW-1:0] paddr;
    logic [msts_pkg::APB_DW-1:0] pwdata;
    logic [msts_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    search_scoreboard sb;
    bit               burst;
    int unsigned      sweep_counts [10] = '{1024, 2047, 32, 33, 34, 65, 1, 2, 0, 1025};

    multiway_sorted_table_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .key         (key),
        .done        (done),
        .position    (position),
        .empty_table (empty_table),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    // Answers are valid for one cycle only; take them at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(position, empty_table);
    end

    // Hands one item to the block after a random gap (none in burst mode) and waits for acceptance.
    // start stays high when the next item follows without a gap.
    task automatic send_item(logic item_op, int unsigned idx, logic [KEY_W-1:0] item_key);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= item_op;
        entry_index <= idx[AW-1:0];
        key <= item_key;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(item_op, idx[AW-1:0], item_key);
    endtask

    // Holds the sender off until every answer is in and the block has settled.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [msts_pkg::REG_IW-1:0] index, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == msts_pkg::REG_ENTRIES_IN_USE)
            sb.set_entries(data);
    endtask

    // Query keys mostly sit on or right next to table entries in the searched span.
    function automatic logic [KEY_W-1:0] query_key(int unsigned span);
        int unsigned pick, n;
        n = (span > DEPTH) ? DEPTH : span;
        pick = $urandom_range(0, 9);
        if (n == 0 || pick == 6 || pick == 7)
            return $urandom;
        if (pick < 6)
            return sb.key_store[$urandom_range(0, n - 1)] + $urandom_range(0, 2) - 1;
        if (pick == 8)
            return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        return $urandom_range(0, 1) ? sb.key_store[0] - 1 : sb.key_store[n - 1];
    endfunction

    initial
    begin
        int unsigned fill_phase, j, span, prefix, idx;
        longint fill_acc, lo_v, hi_v, val;
        sb = new();
        burst = 1'b0;
        start <= 1'b0;
        op <= msts_pkg::OP_LOAD;
        entry_index <= '0;
        key <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset the count is zero: queries see an empty table.
        send_item(msts_pkg::OP_QUERY, 0, KEY_MIN);
        send_item(msts_pkg::OP_QUERY, DEPTH - 1, KEY_MAX);

        // A small table of four keys up to the key maximum, plus the last index.
        send_item(msts_pkg::OP_LOAD, 0, -100);
        send_item(msts_pkg::OP_LOAD, 1, -5);
        send_item(msts_pkg::OP_LOAD, 2, 7);
        send_item(msts_pkg::OP_LOAD, 3, KEY_MAX);
        send_item(msts_pkg::OP_LOAD, DEPTH - 1, KEY_MAX);

        // A single searched entry is still compared.
        drain_results();
        write_reg(msts_pkg::REG_ENTRIES_IN_USE, 1);
        send_item(msts_pkg::OP_QUERY, 0, -101);
        send_item(msts_pkg::OP_QUERY, 0, -100);
        send_item(msts_pkg::OP_QUERY, 0, KEY_MIN);
        send_item(msts_pkg::OP_QUERY, 0, KEY_MAX);

        // Four entries: below all, between, on the largest key.
        drain_results();
        write_reg(msts_pkg::REG_ENTRIES_IN_USE, 4);
        send_item(msts_pkg::OP_QUERY, 0, KEY_MAX);
        send_item(msts_pkg::OP_QUERY, 0, KEY_MIN);
        send_item(msts_pkg::OP_QUERY, 0, 7);
        send_item(msts_pkg::OP_QUERY, 0, 6);
        send_item(msts_pkg::OP_QUERY, 0, KEY_MAX - 1);

        // A write to the spare register address must leave the count alone.
        drain_results();
        write_reg(REG_SPARE, 32'h0000_0000);
        send_item(msts_pkg::OP_QUERY, 0, 7);

        // An explicit count of zero gives the empty flag again.
        drain_results();
        write_reg(msts_pkg::REG_ENTRIES_IN_USE, 0);
        send_item(msts_pkg::OP_QUERY, 0, 5);

        // Fill the whole table in ascending order with some repeated keys.
        // Each phase searches only the part that is already loaded.
        prefix = 4;
        fill_acc = -64'sd2147483648 + 50;
        for (fill_phase = 0; fill_phase < 8; fill_phase++)
        begin
            drain_results();
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, prefix) : prefix;
            write_reg(msts_pkg::REG_ENTRIES_IN_USE, ($urandom & ~32'h7ff) | span);
            burst = ($urandom_range(0, 2) == 0);
            for (j = 0; j < 128; j++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(msts_pkg::OP_QUERY, $urandom_range(0, DEPTH - 1),
                              query_key(span));
                if ($urandom_range(0, 7) != 0)
                    fill_acc += $urandom_range(0, 7000000);
                send_item(msts_pkg::OP_LOAD, fill_phase * 128 + j, fill_acc[31:0]);
            end
            prefix = (fill_phase + 1) * 128;
        end

        // Sweep counts around the stride and linear-scan boundaries and past
        // the table depth, with entry rewrites that mostly keep the order.
        sweep_counts[8] = $urandom_range(1, DEPTH);
        for (fill_phase = 0; fill_phase < 10; fill_phase++)
        begin
            drain_results();
            span = sweep_counts[fill_phase];
            write_reg(msts_pkg::REG_ENTRIES_IN_USE, ($urandom & ~32'h7ff) | span);
            burst = ($urandom_range(0, 2) == 0);
            for (j = 0; j < 14; j++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    idx = $urandom_range(0, DEPTH - 1);
                    if ($urandom_range(0, 4) == 0)
                        val = longint'($urandom);
                    else
                    begin
                        lo_v = (idx > 0) ? longint'(sb.key_store[idx - 1]) : -64'sd2147483648;
                        hi_v = (idx < DEPTH - 1) ? longint'(sb.key_store[idx + 1])
                                                 : 64'sd2147483647;
                        val = (hi_v < lo_v) ? lo_v
                                            : lo_v + (longint'($urandom) % (hi_v - lo_v + 1));
                    end
                    send_item(msts_pkg::OP_LOAD, idx, val[31:0]);
                end
                else
                    send_item(msts_pkg::OP_QUERY, $urandom_range(0, DEPTH - 1),
                              query_key(span));
            end
        end

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: multiway_sorted_table_search.f
rtl/msts_pkg.sv
rtl/msts_cell.sv
rtl/msts_ctrl.sv
rtl/multiway_sorted_table_search.sv
rtl/msts_checker.sv
bench/tb_top.sv
